[design/tssa_pkg.sv]
package tssa_pkg;

	// Default sizes of the sprite pool and the string slot table
	localparam int NUM_SPRITES_DEF = 32;
	localparam int NUM_SLOTS_DEF   = 8;

	// Operation codes of a command
	localparam logic [1:0] OP_BEGIN = 2'd0;
	localparam logic [1:0] OP_CHAR  = 2'd1;
	localparam logic [1:0] OP_END   = 2'd2;
	localparam logic [1:0] OP_FREE  = 2'd3;

	// Result kinds
	localparam logic [1:0] KIND_WRITE  = 2'd0;
	localparam logic [1:0] KIND_STATUS = 2'd1;
	localparam logic [1:0] KIND_DROP   = 2'd2;
	localparam logic [1:0] KIND_DONE   = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_ATTR_BASE  = 2'd0;
	localparam logic [1:0] REG_FIRST_OFFS = 2'd1;
	localparam logic [1:0] REG_FONT_BASE  = 2'd2;

	// Configuration reset values
	localparam logic [15:0] ATTR_BASE_RST  = 16'hFC00;
	localparam logic [9:0]  FIRST_OFFS_RST = 10'd0;
	localparam logic [8:0]  FONT_BASE_RST  = 9'd0;

	// Attribute byte constants
	localparam logic [7:0] Z_DEPTH_BYTE = 8'h0C;
	localparam logic [3:0] PAL_MASK     = 4'hF;
	localparam logic [2:0] RELEASE_BYTE = 3'd6;
	localparam logic [2:0] LAST_BYTE    = 3'd7;
	localparam logic [5:0] CHARS_MAX    = 6'd63;

	typedef struct packed {
		logic [1:0] operation;
		logic [3:0] requested_slot;
		logic [7:0] char_code;
		logic [9:0] x_pos;
		logic [9:0] y_pos;
		logic [3:0] palette;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] vram_addr;
		logic [7:0]  data;
		logic [3:0]  slot;
		logic        last;
	} res_t;

endpackage

[design/tssa_ram.sv]
module tssa_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, register the read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/text_sprite_slot_allocator_unit.sv]
// Channel   Direction  Handshake                Payload
// command   in         start, busy              cmd (tssa_pkg::cmd_t)
// result    out        result_strobe            result (tssa_pkg::res_t)
// config    in/out     psel, penable, pready    paddr, pwdata, prdata
//
// A command is taken when start is high and busy is low; busy stays high until the
// final result of the command has been registered. Begin with a requested slot goes
// to the grant state; with slot 0 it first searches the slot counts for a free slot.
// A character scans sprite owner entries from the current scan position (one owner
// memory read per cycle, each checked after the registered read) and then emits
// eight attribute writes. End scans the owner memory from the current scan position
// and free from entry 0. Commands that report at once do not raise busy.
// Reset clears the owner valid bits and slot counts at once; no clearing pass.
// Each result is shown for one cycle; the receiver cannot stall.
module text_sprite_slot_allocator_unit #(
	parameter int NUM_SPRITES = tssa_pkg::NUM_SPRITES_DEF,
	parameter int NUM_SLOTS   = tssa_pkg::NUM_SLOTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  tssa_pkg::cmd_t cmd,
	output logic           result_strobe,
	output tssa_pkg::res_t result,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [3:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	import tssa_pkg::*;

	localparam int SPR_IW  = (NUM_SPRITES > 1) ? $clog2(NUM_SPRITES) : 1;
	localparam int SCAN_W  = $clog2(NUM_SPRITES + 1);
	localparam int SLOT_IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SLOT_SRCH,
		ST_GRANT,
		ST_SCAN,
		ST_ATTR
	} state_t;

	// Configuration registers
	logic [15:0] attr_base_q;
	logic [9:0]  first_offs_q;
	logic [8:0]  font_base_q;

	// Sequencer and string state
	state_t              state_q;
	logic                busy_q;
	logic                res_stb_q;
	res_t                res_q;
	cmd_t                cmd_q;
	logic [3:0]          active_q;
	logic [3:0]          slot_q;
	logic [3:0]          grant_q;
	logic                rel_mode_q;
	logic [SCAN_W-1:0]   scan_idx_q;
	logic [SCAN_W-1:0]   rd_ptr_q;
	logic                chk_vld_s1;
	logic [SPR_IW-1:0]   chk_idx_s1;
	logic [SPR_IW-1:0]   spr_q;
	logic [2:0]          byte_q;
	logic [SLOT_IW-1:0]  srch_q;
	logic [5:0]          chars_q;
	logic [9:0]          str_x_q;
	logic [9:0]          str_y_q;
	logic [3:0]          str_pal_q;
	logic [5:0]          cnt_q [NUM_SLOTS];
	logic [NUM_SPRITES-1:0] own_vld_q;

	// Datapath signals
	logic [3:0]        owner_rd;
	logic [3:0]        owner_cur;
	logic              hit;
	logic              scan_end;
	logic              ram_we;
	logic [3:0]        slot_m1;
	logic [SLOT_IW-1:0] slot_idx;
	logic [SPR_IW-1:0] addr_idx;
	logic [2:0]        addr_byte;
	logic [15:0]       attr_addr;
	logic [12:0]       tile_addr;
	logic [10:0]       x_val;
	logic [7:0]        attr_byte;
	logic              accept;
	logic              cfg_wr;

	assign accept = start && !busy_q;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Configuration port
	assign pready = 1'b1;

	always_comb begin
		case (paddr[3:2])
			REG_ATTR_BASE:  prdata = {16'd0, attr_base_q};
			REG_FIRST_OFFS: prdata = {22'd0, first_offs_q};
			REG_FONT_BASE:  prdata = {23'd0, font_base_q};
			default:        prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_base_q  <= ATTR_BASE_RST;
			first_offs_q <= FIRST_OFFS_RST;
			font_base_q  <= FONT_BASE_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_ATTR_BASE:  attr_base_q  <= pwdata[15:0];
				REG_FIRST_OFFS: first_offs_q <= pwdata[9:0];
				REG_FONT_BASE:  font_base_q  <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	// Sprite owner memory; an entry without its valid bit reads as no owner
	tssa_ram #(
		.WIDTH(4),
		.DEPTH(NUM_SPRITES)
	) u_owner_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(chk_idx_s1),
		.wdata(slot_q),
		.raddr(rd_ptr_q[SPR_IW-1:0]),
		.rdata(owner_rd)
	);

	// Owner compare: release looks for the slot, a character for the slot or free
	assign owner_cur = own_vld_q[chk_idx_s1] ? owner_rd : 4'd0;
	assign hit = chk_vld_s1 && ((owner_cur == slot_q)
		|| (!rel_mode_q && owner_cur == 4'd0));
	assign scan_end = !chk_vld_s1 && (rd_ptr_q == SCAN_W'(NUM_SPRITES));
	assign ram_we = (state_q == ST_SCAN) && hit && !rel_mode_q;

	assign slot_m1  = slot_q - 4'd1;
	assign slot_idx = slot_m1[SLOT_IW-1:0];

	// Shared attribute address adder
	assign addr_idx  = (state_q == ST_ATTR) ? spr_q : chk_idx_s1;
	assign addr_byte = (state_q == ST_ATTR) ? byte_q : RELEASE_BYTE;
	assign attr_addr = attr_base_q + 16'(first_offs_q) + 16'({addr_idx, 3'b000})
		+ 16'(addr_byte);

	// Select the attribute byte
	assign tile_addr = {1'b0, font_base_q, 3'b000} + {5'd0, cmd_q.char_code};
	assign x_val     = {1'b0, str_x_q} + {2'b00, chars_q, 3'b000};

	always_comb begin
		case (byte_q)
			3'd0:    attr_byte = tile_addr[7:0];
			3'd1:    attr_byte = {3'b000, tile_addr[12:8]};
			3'd2:    attr_byte = x_val[7:0];
			3'd3:    attr_byte = {5'd0, x_val[10:8]};
			3'd4:    attr_byte = str_y_q[7:0];
			3'd5:    attr_byte = {6'd0, str_y_q[9:8]};
			3'd6:    attr_byte = Z_DEPTH_BYTE;
			default: attr_byte = {4'd0, str_pal_q & PAL_MASK};
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			busy_q     <= 1'b0;
			res_stb_q  <= 1'b0;
			res_q      <= '0;
			cmd_q      <= '0;
			active_q   <= 4'd0;
			slot_q     <= 4'd0;
			grant_q    <= 4'd0;
			rel_mode_q <= 1'b0;
			scan_idx_q <= '0;
			rd_ptr_q   <= '0;
			chk_vld_s1 <= 1'b0;
			chk_idx_s1 <= '0;
			spr_q      <= '0;
			byte_q     <= 3'd0;
			srch_q     <= '0;
			chars_q    <= 6'd0;
			str_x_q    <= 10'd0;
			str_y_q    <= 10'd0;
			str_pal_q  <= 4'd0;
			own_vld_q  <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				cnt_q[i] <= 6'd0;
			end
		end else begin
			res_stb_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q <= cmd;
						case (cmd.operation)
							OP_BEGIN: begin
								busy_q <= 1'b1;
								if (cmd.requested_slot == 4'd0) begin
									srch_q  <= '0;
									state_q <= ST_SLOT_SRCH;
								end else begin
									grant_q <= (cmd.requested_slot <= 4'(NUM_SLOTS))
										? cmd.requested_slot : 4'd0;
									state_q <= ST_GRANT;
								end
							end
							OP_CHAR: begin
								if (active_q == 4'd0) begin
									res_stb_q <= 1'b1;
									res_q <= '{KIND_DROP, 16'd0, cmd.char_code, 4'd0, 1'b1};
								end else begin
									busy_q     <= 1'b1;
									slot_q     <= active_q;
									rel_mode_q <= 1'b0;
									rd_ptr_q   <= scan_idx_q;
									chk_vld_s1 <= 1'b0;
									state_q    <= ST_SCAN;
								end
							end
							OP_END: begin
								if (active_q == 4'd0) begin
									res_stb_q <= 1'b1;
									res_q <= '{KIND_DONE, 16'd0, 8'd0, 4'd0, 1'b1};
								end else begin
									busy_q     <= 1'b1;
									slot_q     <= active_q;
									rel_mode_q <= 1'b1;
									rd_ptr_q   <= scan_idx_q;
									chk_vld_s1 <= 1'b0;
									state_q    <= ST_SCAN;
								end
							end
							default: begin
								if (cmd.requested_slot == 4'd0
									|| cmd.requested_slot > 4'(NUM_SLOTS)) begin
									res_stb_q <= 1'b1;
									res_q <= '{KIND_DONE, 16'd0, 8'd0, cmd.requested_slot,
										1'b1};
								end else begin
									busy_q     <= 1'b1;
									slot_q     <= cmd.requested_slot;
									rel_mode_q <= 1'b1;
									rd_ptr_q   <= '0;
									chk_vld_s1 <= 1'b0;
									state_q    <= ST_SCAN;
								end
							end
						endcase
					end
				end

				// Walk the slot counts for the first free slot
				ST_SLOT_SRCH: begin
					if (cnt_q[srch_q] == 6'd0) begin
						grant_q <= 4'(srch_q) + 4'd1;
						state_q <= ST_GRANT;
					end else if (srch_q == SLOT_IW'(NUM_SLOTS - 1)) begin
						grant_q <= 4'd0;
						state_q <= ST_GRANT;
					end else begin
						srch_q <= srch_q + SLOT_IW'(1);
					end
				end

				// Open the string and report the granted slot
				ST_GRANT: begin
					active_q <= grant_q;
					if (grant_q != 4'd0) begin
						scan_idx_q <= '0;
						chars_q    <= 6'd0;
						str_x_q    <= cmd_q.x_pos;
						str_y_q    <= cmd_q.y_pos;
						str_pal_q  <= cmd_q.palette;
					end
					res_stb_q <= 1'b1;
					res_q     <= '{KIND_STATUS, 16'd0, 8'd0, grant_q, 1'b1};
					busy_q    <= 1'b0;
					state_q   <= ST_IDLE;
				end

				// Read one owner entry per cycle, check the one read last cycle
				ST_SCAN: begin
					if (rd_ptr_q < SCAN_W'(NUM_SPRITES)) begin
						rd_ptr_q   <= rd_ptr_q + SCAN_W'(1);
						chk_vld_s1 <= 1'b1;
						chk_idx_s1 <= rd_ptr_q[SPR_IW-1:0];
					end else begin
						chk_vld_s1 <= 1'b0;
					end

					if (hit && !rel_mode_q) begin
						// claim the sprite and move to the attribute writes
						own_vld_q[chk_idx_s1] <= 1'b1;
						spr_q      <= chk_idx_s1;
						scan_idx_q <= SCAN_W'(chk_idx_s1) + SCAN_W'(1);
						byte_q     <= 3'd0;
						chk_vld_s1 <= 1'b0;
						state_q    <= ST_ATTR;
					end else if (hit) begin
						// release the sprite: z depth 0
						own_vld_q[chk_idx_s1] <= 1'b0;
						res_stb_q <= 1'b1;
						res_q     <= '{KIND_WRITE, attr_addr, 8'd0, slot_q, 1'b0};
					end else if (scan_end) begin
						res_stb_q <= 1'b1;
						busy_q    <= 1'b0;
						state_q   <= ST_IDLE;
						case (cmd_q.operation)
							OP_CHAR: begin
								scan_idx_q <= SCAN_W'(NUM_SPRITES);
								res_q <= '{KIND_DROP, 16'd0, cmd_q.char_code, slot_q, 1'b1};
							end
							OP_END: begin
								cnt_q[slot_idx] <= chars_q;
								res_q <= '{KIND_DONE, 16'd0, {2'b00, chars_q}, slot_q, 1'b1};
								active_q   <= 4'd0;
								scan_idx_q <= '0;
								chars_q    <= 6'd0;
							end
							default: begin
								cnt_q[slot_idx] <= 6'd0;
								res_q <= '{KIND_DONE, 16'd0, 8'd0, slot_q, 1'b1};
								if (active_q == slot_q) begin
									active_q   <= 4'd0;
									scan_idx_q <= '0;
									chars_q    <= 6'd0;
								end
							end
						endcase
					end
				end

				// Emit the eight attribute bytes of the claimed sprite
				ST_ATTR: begin
					res_stb_q <= 1'b1;
					res_q <= '{KIND_WRITE, attr_addr, attr_byte, slot_q, byte_q == LAST_BYTE};
					byte_q <= byte_q + 3'd1;
					if (byte_q == LAST_BYTE) begin
						if (chars_q != CHARS_MAX) begin
							chars_q <= chars_q + 6'd1;
						end
						busy_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end

				default: begin
					busy_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy          = busy_q;
	assign result_strobe = res_stb_q;
	assign result        = res_q;

	// busy drops only together with the final result of a transaction
	a_busy_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_strobe && result.last)
		else $error("busy dropped without a final result");

	// non-final results come only from multi-cycle work
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.last |-> busy)
		else $error("non-final result while idle");

	// attribute writes always belong to a slot
	a_write_slot: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.kind == KIND_WRITE |-> result.slot != 4'd0)
		else $error("attribute write with no slot");

	// open slot and scan position stay in range
	a_active_rng: assert property (@(posedge clk) disable iff (!arst_n)
		active_q <= 4'(NUM_SLOTS))
		else $error("open slot out of range");

	a_scan_rng: assert property (@(posedge clk) disable iff (!arst_n)
		scan_idx_q <= SCAN_W'(NUM_SPRITES))
		else $error("scan position out of range");

endmodule
